### hdl/tprc_pkg.sv
package tprc_pkg;

   // frame offsets (ethernet 14 + ipv4 20 + tcp 20)
   localparam int unsigned OFF_W         = 6;
   localparam logic [OFF_W-1:0] OFF_ETYPE_HI  = 6'd12;
   localparam logic [OFF_W-1:0] OFF_ETYPE_LO  = 6'd13;
   localparam logic [OFF_W-1:0] OFF_PROTO     = 6'd23;
   localparam logic [OFF_W-1:0] OFF_HOLD_FIRST = 6'd36;
   localparam logic [OFF_W-1:0] OFF_PORT_LO   = 6'd37;
   localparam logic [OFF_W-1:0] OFF_CSUM_HI   = 6'd50;
   localparam logic [OFF_W-1:0] OFF_CSUM_LO   = 6'd51;
   localparam logic [OFF_W-1:0] OFF_HOLD_LAST = 6'd53;
   localparam logic [OFF_W-1:0] OFF_FULL      = 6'd54;

   localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
   localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
   localparam logic [7:0] PROTO_TCP     = 8'h06;

   // queue between parser and emitter
   localparam int unsigned QUEUE_DEPTH = 32;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // configuration register indexes
   localparam logic CSR_MATCH_PORT = 1'b0;
   localparam logic CSR_NEW_PORT   = 1'b1;

   typedef enum logic [2:0] {
      KIND_PLAIN,
      KIND_PORT_HI,
      KIND_PORT_LO,
      KIND_CSUM_HI,
      KIND_CSUM_LO
   } kind_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       held;     // byte of the hold window
      logic       rel_end;  // byte that closes the hold window
      kind_type   kind;
   } entry_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic [15:0] new_port;
      logic [15:0] csum;
   } release_type;

endpackage

### hdl/tprc_front.sv
module tprc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   input  logic [15:0]           match_port,
   input  logic [15:0]           new_port,
   output tprc_pkg::entry_type   entry,
   output tprc_pkg::release_type rel
);

   logic [tprc_pkg::OFF_W-1:0] offset_ff, offset_in;
   logic        ipv4_ff, ipv4_in;
   logic        tcp_ff, tcp_in;
   logic        hit_ff, hit_in;
   logic [7:0]  port_hi_ff, port_hi_in;
   logic [7:0]  csum_hi_ff, csum_hi_in;
   logic [15:0] csum_ff, csum_in;

   logic        in_hold;
   logic [15:0] hc;
   logic [17:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;

   // incremental update: hc' = ~(~hc + ~m + m')
   always_comb begin
      hc    = {csum_hi_ff, data_byte};
      sum   = {2'b00, ~hc} + {2'b00, ~match_port} + {2'b00, new_port};
      fold1 = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
      fold2 = fold1[15:0] + {15'd0, fold1[16]};
   end

   always_comb begin
      in_hold = (offset_ff >= tprc_pkg::OFF_HOLD_FIRST) &&
                (offset_ff < tprc_pkg::OFF_FULL);

      entry.data    = data_byte;
      entry.last    = last_byte;
      entry.held    = in_hold;
      entry.rel_end = in_hold && (last_byte || offset_ff == tprc_pkg::OFF_HOLD_LAST);
      case (offset_ff)
         tprc_pkg::OFF_HOLD_FIRST: entry.kind = tprc_pkg::KIND_PORT_HI;
         tprc_pkg::OFF_PORT_LO:    entry.kind = tprc_pkg::KIND_PORT_LO;
         tprc_pkg::OFF_CSUM_HI:    entry.kind = tprc_pkg::KIND_CSUM_HI;
         tprc_pkg::OFF_CSUM_LO:    entry.kind = tprc_pkg::KIND_CSUM_LO;
         default:                  entry.kind = tprc_pkg::KIND_PLAIN;
      endcase

      // rewrite only when the full window arrived; an early end passes unchanged
      rel.valid    = accept && entry.rel_end;
      rel.hit      = hit_ff && (offset_ff == tprc_pkg::OFF_HOLD_LAST);
      rel.new_port = new_port;
      rel.csum     = csum_ff;
   end

   always_comb begin
      offset_in  = offset_ff;
      ipv4_in    = ipv4_ff;
      tcp_in     = tcp_ff;
      hit_in     = hit_ff;
      port_hi_in = port_hi_ff;
      csum_hi_in = csum_hi_ff;
      csum_in    = csum_ff;
      if (accept) begin
         case (offset_ff)
            tprc_pkg::OFF_ETYPE_HI:   ipv4_in = (data_byte == tprc_pkg::ETYPE_IPV4_HI);
            tprc_pkg::OFF_ETYPE_LO:   ipv4_in = ipv4_ff &&
                                                (data_byte == tprc_pkg::ETYPE_IPV4_LO);
            tprc_pkg::OFF_PROTO:      tcp_in = (data_byte == tprc_pkg::PROTO_TCP);
            tprc_pkg::OFF_HOLD_FIRST: port_hi_in = data_byte;
            tprc_pkg::OFF_PORT_LO:    hit_in = ipv4_ff && tcp_ff &&
                                               ({port_hi_ff, data_byte} == match_port);
            tprc_pkg::OFF_CSUM_HI:    csum_hi_in = data_byte;
            tprc_pkg::OFF_CSUM_LO:    csum_in = ~fold2;
            default: ;
         endcase
         if (last_byte) begin
            offset_in = '0;
            ipv4_in   = 1'b0;
            tcp_in    = 1'b0;
            hit_in    = 1'b0;
         end else if (offset_ff < tprc_pkg::OFF_FULL) begin
            offset_in = offset_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         ipv4_ff   <= 1'b0;
         tcp_ff    <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         ipv4_ff   <= ipv4_in;
         tcp_ff    <= tcp_in;
         hit_ff    <= hit_in;
      end
      port_hi_ff <= port_hi_in;
      csum_hi_ff <= csum_hi_in;
      csum_ff    <= csum_in;
   end

endmodule

### hdl/tprc_queue.sv
module tprc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tprc_pkg::entry_type push_entry,
   input  logic                pop,
   output tprc_pkg::entry_type head,
   output logic                empty,
   output logic                full
);

   tprc_pkg::entry_type mem_ff [tprc_pkg::QUEUE_DEPTH];

   logic [tprc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tprc_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tprc_pkg::QUEUE_AW:0]   count_ff, count_in;

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == (tprc_pkg::QUEUE_AW+1)'(tprc_pkg::QUEUE_DEPTH));
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/tprc_back.sv
module tprc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tprc_pkg::release_type rel,
   input  tprc_pkg::entry_type   head,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_last
);

   logic        pending_ff, pending_in;
   logic        hit_ff, hit_in;
   logic [15:0] port_ff, port_in;
   logic [15:0] csum_ff, csum_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        out_free;
   logic [7:0]  sub_byte;

   always_comb begin
      out_free = !valid_ff || !rsp_stall;
      pop      = out_free && !empty && (!head.held || pending_ff);

      sub_byte = head.data;
      if (hit_ff) begin
         case (head.kind)
            tprc_pkg::KIND_PORT_HI: sub_byte = port_ff[15:8];
            tprc_pkg::KIND_PORT_LO: sub_byte = port_ff[7:0];
            tprc_pkg::KIND_CSUM_HI: sub_byte = csum_ff[15:8];
            tprc_pkg::KIND_CSUM_LO: sub_byte = csum_ff[7:0];
            default:                sub_byte = head.data;
         endcase
      end

      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (pop) begin
         valid_in = 1'b1;
         byte_in  = sub_byte;
         last_in  = head.last;
      end else if (out_free) begin
         valid_in = 1'b0;
      end

      pending_in = pending_ff;
      hit_in     = hit_ff;
      port_in    = port_ff;
      csum_in    = csum_ff;
      if (pop && head.rel_end) begin
         pending_in = 1'b0;
      end
      if (rel.valid) begin
         pending_in = 1'b1;
         hit_in     = rel.hit;
         port_in    = rel.new_port;
         csum_in    = rel.csum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         hit_ff     <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         hit_ff     <= hit_in;
         valid_ff   <= valid_in;
      end
      port_ff <= port_in;
      csum_ff <= csum_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

endmodule

### hdl/tcp_port_rewrite_checksum_top.sv
// tcp destination-port rewrite with incremental checksum update. frames stream in one byte
// per request and leave in the same order and length. when the ethertype is ipv4, the
// protocol byte (ip header taken as 20 bytes) is tcp and the destination port equals
// match_port, the port becomes new_port and the tcp checksum is patched with one's-complement
// arithmetic and end-around carry. bytes 36 to 53 are held until the frame is known to reach
// 54 bytes; frames ending earlier pass unchanged. throughput is one byte per clock sustained
// while rsp_stall stays low; a parser front end classifies each byte and writes it into a
// 32-entry queue, and an emitter back end releases it through an output register. a held
// byte cannot leave before the byte closing the hold window is accepted, and bytes queued
// behind the window wait behind it while the input runs at full rate. req_stall rises only
// when the queue is full, which happens only while rsp_stall holds the output back.
// csr_ready is always high; configuration is expected to be written between frames only
module tcp_port_rewrite_checksum_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] match_port_ff;
   logic [15:0] new_port_ff;

   logic                  req_accept;
   logic                  q_full;
   logic                  q_empty;
   logic                  q_pop;
   tprc_pkg::entry_type   push_entry;
   tprc_pkg::entry_type   q_head;
   tprc_pkg::release_type rel;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_port_ff <= '0;
         new_port_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tprc_pkg::CSR_MATCH_PORT: match_port_ff <= csr_data;
            tprc_pkg::CSR_NEW_PORT:   new_port_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // every accepted byte goes straight into the queue
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   // parser: offset tracking, header checks and checksum patch value
   tprc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .match_port (match_port_ff),
      .new_port   (new_port_ff),
      .entry      (push_entry),
      .rel        (rel)
   );

   // byte queue between parser and emitter
   tprc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // emitter: holds window bytes until released, substitutes port and checksum
   tprc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .rel          (rel),
      .head         (q_head),
      .empty        (q_empty),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

### dv/tb_tcp_port_rewrite_checksum_top.sv
`timescale 1ns / 1ps

module tb_tcp_port_rewrite_checksum_top;

   // frame layout as the testbench sees it (ethernet 14 + ipv4 20 + tcp 20)
   localparam int ETYPE_HI_POS = 12;
   localparam int ETYPE_LO_POS = 13;
   localparam int PROTO_POS    = 23;
   localparam int DPORT_HI_POS = 36;
   localparam int DPORT_LO_POS = 37;
   localparam int CSUM_HI_POS  = 50;
   localparam int CSUM_LO_POS  = 51;
   localparam int WINDOW_END   = 53;
   localparam int FRAME_FULL   = 54;
   localparam int WINDOW_DEPTH = 18;
   localparam int CSUM_SLOT    = CSUM_HI_POS - DPORT_HI_POS;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_PROTO_TCP   = 8'h06;

   // run control
   localparam int N_PHASES        = 4;
   localparam int PHASE_BYTES     = 20;
   localparam int PRESSURE_BYTES  = 60;   // phase that runs against the held-off receiver
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 120;  // long enough to fill the 32-entry queue
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTED    = 10;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } wire_byte_type;

   // port and checksum typed in for a directed frame, checked on the way out
   typedef struct packed {
      logic        check;
      logic [15:0] port;
      logic [15:0] csum;
   } pinned_fields_type;

   typedef struct packed {
      logic        load_cfg;
      logic [15:0] cfg_match;
      logic [15:0] cfg_new;
      logic [15:0] ethertype;
      logic [7:0]  ip_proto;
      logic [15:0] dst_port;
      logic [15:0] tcp_csum;
      logic [7:0]  frame_len;
      logic        pinned;
      logic [15:0] pin_port;
      logic [15:0] pin_csum;
   } frame_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_last;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_data;

   tcp_port_rewrite_checksum_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // directed frames; pinned rows carry port and checksum that are obvious by hand,
   // the rest rely on the rewrite predictor alone
   frame_row_type directed_rows [6] = '{
      // after reset both ports are zero: a port of zero is rewritten to itself and
      // a checksum of ffff folds to its one's-complement twin 0000
      '{1'b0, 16'h0000, 16'h0000, ETHERTYPE_IPV4, IP_PROTO_TCP, 16'h0000, 16'hffff,
        8'd54, 1'b1, 16'h0000, 16'h0000},
      // extreme ports: ffff rewritten to 0000
      '{1'b1, 16'hffff, 16'h0000, ETHERTYPE_IPV4, IP_PROTO_TCP, 16'hffff, 16'h0000,
        8'd54, 1'b1, 16'h0000, 16'h0000},
      // extreme ports the other way: 0000 rewritten to ffff
      '{1'b1, 16'h0000, 16'hffff, ETHERTYPE_IPV4, IP_PROTO_TCP, 16'h0000, 16'h0000,
        8'd54, 1'b1, 16'hffff, 16'h0000},
      // one-byte frame
      '{1'b0, 16'h0000, 16'hffff, ETHERTYPE_IPV4, IP_PROTO_TCP, 16'h0000, 16'h1234,
        8'd1, 1'b0, 16'h0000, 16'h0000},
      // ends right after a matching port: must still pass unchanged
      '{1'b0, 16'h0000, 16'hffff, ETHERTYPE_IPV4, IP_PROTO_TCP, 16'h0000, 16'h1234,
        8'd38, 1'b0, 16'h0000, 16'h0000},
      // ends one byte short of the full header
      '{1'b0, 16'h0000, 16'hffff, ETHERTYPE_IPV4, IP_PROTO_TCP, 16'h0000, 16'h1234,
        8'd53, 1'b0, 16'h0000, 16'h0000}
   };

   // ---------------------------------------------------------------- rewrite predictor
   logic [15:0] cfg_match_port = '0;
   logic [15:0] cfg_new_port   = '0;
   logic [5:0]  frm_off        = '0;
   logic        eth_ipv4       = 1'b0;
   logic        ip_tcp         = 1'b0;
   logic        dport_hit      = 1'b0;
   logic [7:0]  window_bytes [WINDOW_DEPTH];
   int          window_cnt     = 0;

   wire_byte_type     expected_bytes [$];
   pinned_fields_type pinned_frames [$];
   pinned_fields_type cur_pins;
   int                out_pos = 0;

   // bookkeeping for the summary
   int mismatches    = 0;
   int frames_sent   = 0;
   int bytes_sent    = 0;
   int bytes_checked = 0;
   int rewrites      = 0;
   int early_ends    = 0;
   int cfg_writes    = 0;

   // knobs shared between the stimulus and the receiver process
   logic tx_quiet     = 1'b0;
   logic rx_quiet     = 1'b0;
   logic hold_off_now = 1'b0;

   function automatic void flag_error(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTED)
         $display("%t mismatch: %s", $time, msg);
   endfunction

   // flush the hold window in arrival order, end of frame on the final entry
   function automatic void release_window(logic last);
      wire_byte_type wb;
      for (int k = 0; k < window_cnt; k++) begin
         wb.data = window_bytes[k];
         wb.last = last && (k == window_cnt - 1);
         expected_bytes.push_back(wb);
      end
      window_cnt = 0;
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic last);
      logic [15:0]   old_csum;
      logic [15:0]   new_csum;
      logic [17:0]   acc;
      int            pos;
      wire_byte_type wb;
      pos = frm_off;
      if (pos == ETYPE_HI_POS)
         eth_ipv4 = (b == ETHERTYPE_IPV4[15:8]);
      else if (pos == ETYPE_LO_POS)
         eth_ipv4 = eth_ipv4 && (b == ETHERTYPE_IPV4[7:0]);
      else if (pos == PROTO_POS)
         ip_tcp = (b == IP_PROTO_TCP);

      if (pos < DPORT_HI_POS || pos >= FRAME_FULL) begin
         wb.data = b;
         wb.last = last;
         expected_bytes.push_back(wb);
      end else begin
         window_bytes[pos - DPORT_HI_POS] = b;
         window_cnt = pos - DPORT_HI_POS + 1;
         if (pos == DPORT_LO_POS)
            dport_hit = eth_ipv4 && ip_tcp &&
                        ({window_bytes[0], window_bytes[1]} == cfg_match_port);
         if (pos == WINDOW_END) begin
            if (dport_hit) begin
               // rfc 1624 eqn 3 with end-around carry folded twice
               old_csum = {window_bytes[CSUM_SLOT], window_bytes[CSUM_SLOT + 1]};
               acc = {2'b00, ~old_csum} + {2'b00, ~cfg_match_port} + {2'b00, cfg_new_port};
               acc = {2'b00, acc[15:0]} + {16'h0000, acc[17:16]};
               acc = {2'b00, acc[15:0]} + {16'h0000, acc[17:16]};
               new_csum = ~acc[15:0];
               window_bytes[0] = cfg_new_port[15:8];
               window_bytes[1] = cfg_new_port[7:0];
               window_bytes[CSUM_SLOT] = new_csum[15:8];
               window_bytes[CSUM_SLOT + 1] = new_csum[7:0];
               rewrites++;
            end
            release_window(last);
         end else if (last) begin
            early_ends++;
            release_window(1'b1);
         end
      end

      if (last) begin
         frm_off = '0;
         eth_ipv4 = 1'b0;
         ip_tcp = 1'b0;
         dport_hit = 1'b0;
         window_cnt = 0;
      end else if (pos < FRAME_FULL) begin
         frm_off = frm_off + 6'd1;
      end
   endfunction

   function automatic void check_result(logic [7:0] got_byte, logic got_last);
      wire_byte_type want;
      logic [15:0]   pin_word;
      bytes_checked++;
      if (out_pos == 0) begin
         if (pinned_frames.size() != 0) cur_pins = pinned_frames.pop_front();
         else cur_pins = '0;
      end
      if (expected_bytes.size() == 0) begin
         flag_error($sformatf("result byte %h last %b with nothing expected", got_byte, got_last));
      end else begin
         want = expected_bytes.pop_front();
         if (got_byte !== want.data)
            flag_error($sformatf("out_byte at offset %0d: expected %h, got %h",
                                 out_pos, want.data, got_byte));
         if (got_last !== want.last)
            flag_error($sformatf("out_last at offset %0d: expected %b, got %b",
                                 out_pos, want.last, got_last));
      end
      // hand-typed port and checksum of directed frames
      if (cur_pins.check) begin
         pin_word = (out_pos == DPORT_HI_POS || out_pos == DPORT_LO_POS) ?
                    cur_pins.port : cur_pins.csum;
         if ((out_pos == DPORT_HI_POS || out_pos == CSUM_HI_POS) && got_byte !== pin_word[15:8])
            flag_error($sformatf("directed frame offset %0d: expected %h, got %h",
                                 out_pos, pin_word[15:8], got_byte));
         if ((out_pos == DPORT_LO_POS || out_pos == CSUM_LO_POS) && got_byte !== pin_word[7:0])
            flag_error($sformatf("directed frame offset %0d: expected %h, got %h",
                                 out_pos, pin_word[7:0], got_byte));
      end
      out_pos = got_last ? 0 : out_pos + 1;
   endfunction

   // everything that crosses a handshake is picked up here, at the edge it is accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            cfg_writes++;
            if (csr_index == tprc_pkg::CSR_MATCH_PORT) cfg_match_port = csr_data;
            else if (csr_index == tprc_pkg::CSR_NEW_PORT) cfg_new_port = csr_data;
         end
         if (req_valid && !req_stall) begin
            bytes_sent++;
            predict_byte(req_data_byte, req_last_byte);
         end
         if (rsp_valid && !rsp_stall)
            check_result(rsp_out_byte, rsp_out_last);
      end
   end

   // ---------------------------------------------------------------- idling
   // mostly no gap or a short one, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver: random stalls, full rate when asked, one long hold-off on request
   initial begin
      int n;
      forever begin
         n = rx_quiet ? 0 : idle_len();
         if (hold_off_now) begin
            n = HOLD_OFF_CYCLES;
            hold_off_now = 1'b0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // watchdog: ends the run after too long without any handshake
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_tcp_port_rewrite_checksum_top: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus
   function automatic byte_q_type make_frame(logic [15:0] etype, logic [7:0] proto,
                                             logic [15:0] dport, logic [15:0] csum, int len);
      byte_q_type body;
      for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
      if (len > ETYPE_HI_POS) body[ETYPE_HI_POS] = etype[15:8];
      if (len > ETYPE_LO_POS) body[ETYPE_LO_POS] = etype[7:0];
      if (len > PROTO_POS)    body[PROTO_POS]    = proto;
      if (len > DPORT_HI_POS) body[DPORT_HI_POS] = dport[15:8];
      if (len > DPORT_LO_POS) body[DPORT_LO_POS] = dport[7:0];
      if (len > CSUM_HI_POS)  body[CSUM_HI_POS]  = csum[15:8];
      if (len > CSUM_LO_POS)  body[CSUM_LO_POS]  = csum[7:0];
      return body;
   endfunction

   // one frame, one request per byte; valid stays up across back-to-back bytes
   task automatic send_frame(input byte_q_type body, input pinned_fields_type pins);
      int gap;
      pinned_frames.push_back(pins);
      foreach (body[i]) begin
         req_valid     <= 1'b1;
         req_data_byte <= body[i];
         req_last_byte <= (i == body.size() - 1);
         do @(posedge clock); while (req_stall);
         gap = tx_quiet ? 0 : idle_len();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      frames_sent++;
   endtask

   // registers change only with the pipe empty; the first edge lets the last
   // accepted byte reach the predictor before the queue is looked at
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_ports(input logic [15:0] match, input logic [15:0] repl);
      csr_valid <= 1'b1;
      csr_index <= tprc_pkg::CSR_MATCH_PORT;
      csr_data  <= match;
      do @(posedge clock); while (!csr_ready);
      csr_index <= tprc_pkg::CSR_NEW_PORT;
      csr_data  <= repl;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      frame_row_type     row;
      pinned_fields_type pins;
      byte_q_type        body;
      logic [15:0]       match;
      logic [15:0]       repl;
      logic [15:0]       dport;
      logic [15:0]       csum;
      logic [15:0]       etype;
      logic [7:0]        proto;
      int                len;
      int                r;
      int                phase_bytes;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      csr_valid     <= 1'b0;
      csr_index     <= tprc_pkg::CSR_MATCH_PORT;
      csr_data      <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed frames, the first one on the reset values of the registers
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.load_cfg) begin
            wait_idle();
            set_ports(row.cfg_match, row.cfg_new);
         end
         pins = '{row.pinned, row.pin_port, row.pin_csum};
         body = make_frame(row.ethertype, row.ip_proto, row.dst_port, row.tcp_csum,
                           row.frame_len);
         send_frame(body, pins);
      end

      // random phases, each under its own port pair
      for (int phase = 0; phase < N_PHASES; phase++) begin
         match = 16'($urandom_range(0, 65535));
         repl  = 16'($urandom_range(0, 65535));
         case (phase)
            1: repl = match;          // rewrite to the same port
            2: match = 16'hffff;
            3: repl = 16'h0000;
            default: ;
         endcase
         wait_idle();
         set_ports(match, repl);
         // phase 1 fills the block against a held-off receiver, phase 2 runs flat out
         tx_quiet = (phase == 1 || phase == 2);
         rx_quiet = (phase == 2);
         if (phase == 1) hold_off_now = 1'b1;

         phase_bytes = 0;
         while (phase_bytes < ((phase == 1) ? PRESSURE_BYTES : PHASE_BYTES)) begin
            r     = $urandom_range(0, 99);
            etype = ETHERTYPE_IPV4;
            proto = IP_PROTO_TCP;
            dport = ($urandom_range(0, 99) < 80) ? match : 16'($urandom_range(0, 65535));
            csum  = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) == 0) csum = 16'hffff;
            else if ($urandom_range(0, 19) == 0) csum = 16'h0000;
            if (r < 55) begin
               // well-formed tcp frame, mostly just past the header
               len = ($urandom_range(0, 99) < 85) ? $urandom_range(54, 58) :
                                                    $urandom_range(59, 90);
            end else if (r < 75) begin
               // cut short, often inside the hold window
               len = $urandom_range(0, 1) ? $urandom_range(36, 53) : $urandom_range(1, 35);
            end else if (r < 87) begin
               // header that must not match
               case ($urandom_range(0, 2))
                  0: etype = 16'($urandom_range(0, 65535));
                  1: etype = {ETHERTYPE_IPV4[15:8], 8'($urandom_range(1, 255))};
                  default: proto = 8'($urandom_range(0, 255));
               endcase
               len = $urandom_range(54, 60);
            end else begin
               // plain noise
               etype = 16'($urandom_range(0, 65535));
               proto = 8'($urandom_range(0, 255));
               len = $urandom_range(1, 20);
            end
            body = make_frame(etype, proto, dport, csum, len);
            send_frame(body, '0);
            phase_bytes += len;
         end
      end

      // drain, then let the settle period run to catch anything spurious
      wait_idle();
      if (expected_bytes.size() != 0)
         flag_error($sformatf("%0d result bytes never arrived", expected_bytes.size()));

      $display("run covered %0d frames, %0d request bytes, %0d result bytes checked",
               frames_sent, bytes_sent, bytes_checked);
      $display("%0d port rewrites, %0d frames cut inside the hold window, %0d register writes",
               rewrites, early_ends, cfg_writes);
      if (mismatches == 0)
         $display("tb_tcp_port_rewrite_checksum_top: done, clean");
      else
         $display("tb_tcp_port_rewrite_checksum_top: done, errors");
      $finish;
   end

endmodule
